FILE: hw/rtl/fltq31_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fltq31_pkg
// Shared constants and types for the Q31 FIR lattice filter.
// ---------------------------------------------------------------------------
package fltq31_pkg;

    // Number of lattice cells in the chain (1..8)
    localparam int NUM_STAGES = 8;
    // Sample and coefficient width, Q31 fractional shift
    localparam int DATA_W     = 32;
    localparam int Q_SHIFT    = 31;
    localparam int PROD_W     = 2 * DATA_W;
    // Width of the configuration register index
    localparam int CFG_IDX_W  = 8;

    // Data handed from one cell to the next: forward and backward path
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] f;
        logic [DATA_W-1:0] g;
    } lat_link_t;

endpackage

FILE: hw/rtl/fltq31_coef_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fltq31_coef_regs
// Reflection coefficient registers, one per lattice cell.
// ---------------------------------------------------------------------------
module fltq31_coef_regs
    import fltq31_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [CFG_IDX_W-1:0]              wr_index,
    input  logic [DATA_W-1:0]                 wr_data,
    output logic [NUM_STAGES-1:0][DATA_W-1:0] coef
);

    logic [NUM_STAGES-1:0][DATA_W-1:0] coef_reg;

    // Decode the index; writes beyond the last cell are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (wr_en) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (wr_index == CFG_IDX_W'(i)) begin
                    coef_reg[i] <= wr_data;
                end
            end
        end
    end

    assign coef = coef_reg;

endmodule

FILE: hw/rtl/fltq31_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fltq31_cell
// One lattice cell: holds the backward delay, two Q31 products, two adds.
// ---------------------------------------------------------------------------
module fltq31_cell
    import fltq31_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [DATA_W-1:0] coef_k,
    input  lat_link_t         link_in,
    output lat_link_t         link_out
);

    logic signed [DATA_W-1:0] delay_reg;
    logic                     valid_a_reg;
    logic [DATA_W-1:0]        f_a_reg;
    logic [DATA_W-1:0]        gold_a_reg;
    logic signed [PROD_W-1:0] pf_a_reg;
    logic signed [PROD_W-1:0] pg_a_reg;
    logic                     valid_b_reg;
    logic [DATA_W-1:0]        f_b_reg;
    logic [DATA_W-1:0]        g_b_reg;

    logic signed [PROD_W-1:0] pf_next;
    logic signed [PROD_W-1:0] pg_next;

    // Full 64-bit signed products: g_old*k and f*k
    always_comb begin
        pf_next = PROD_W'($signed(delay_reg)) * PROD_W'($signed(coef_k));
        pg_next = PROD_W'($signed(link_in.f)) * PROD_W'($signed(coef_k));
    end

    // Control: valid bits and the backward delay
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            delay_reg   <= '0;
        end else if (en) begin
            valid_a_reg <= link_in.valid;
            valid_b_reg <= valid_a_reg;
            if (link_in.valid) begin
                delay_reg <= $signed(link_in.g);
            end
        end
    end

    // Payload: multiply stage, then shift-by-31 and wrapping add stage
    always_ff @(posedge aclk) begin
        if (en) begin
            f_a_reg    <= link_in.f;
            gold_a_reg <= delay_reg;
            pf_a_reg   <= pf_next;
            pg_a_reg   <= pg_next;
            f_b_reg    <= pf_a_reg[Q_SHIFT+DATA_W-1:Q_SHIFT] + f_a_reg;
            g_b_reg    <= pg_a_reg[Q_SHIFT+DATA_W-1:Q_SHIFT] + gold_a_reg;
        end
    end

    assign link_out = '{valid: valid_b_reg, f: f_b_reg, g: g_b_reg};

endmodule

FILE: hw/rtl/fir_lattice_filter_q31_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fir_lattice_filter_q31_core
// Q31 FIR lattice filter built as a chain of pipelined lattice cells.
// ---------------------------------------------------------------------------
// Accepts one Q31 sample per cycle while the chain is not held and delivers
// one filtered sample per accepted sample, in order. Each cell registers the
// products of its two 32x32 multipliers, then the sums of its two wrapping
// adders. When a result waits on m_tready the whole chain holds and s_tready
// drops. Coefficient writes (cfg_ready is always high) must be made while no
// sample is in flight; indexes at or above NUM_STAGES are ignored. All
// coefficients and backward delays reset to zero.
module fir_lattice_filter_q31_core
    import fltq31_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] sample_in
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [31:0] sample_out
    // Coefficient write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic                              chain_en;
    logic [NUM_STAGES-1:0][DATA_W-1:0] coef;
    lat_link_t                         link [NUM_STAGES+1];

    // Chain advances unless the last cell holds an untaken result
    assign chain_en  = !link[NUM_STAGES].valid || m_tready;
    assign s_tready  = chain_en;
    assign cfg_ready = 1'b1;

    fltq31_coef_regs u_coef_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    // Stage 0 sees the input sample on both paths
    assign link[0] = '{valid: s_tvalid && chain_en, f: s_tdata, g: s_tdata};

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_cell
        fltq31_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (chain_en),
            .coef_k   (coef[i]),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    // Forward path of the last cell is the result
    assign m_tvalid = link[NUM_STAGES].valid;
    assign m_tdata  = link[NUM_STAGES].f;

endmodule

FILE: hw/rtl/fltq31_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fltq31_chk
// Port-level checks for the Q31 FIR lattice filter, bound to the top level.
// ---------------------------------------------------------------------------
module fltq31_chk
    import fltq31_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_W-1:0]    m_tdata,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Held result keeps its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("held result changed");

    // Chain stalls while a result waits
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // Empty output never blocks input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // Coefficient port never back-pressures
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("coefficient write refused");

endmodule

bind fir_lattice_filter_q31_core fltq31_chk u_fltq31_chk (.*);

FILE: tb/tb_fir_lattice_filter_q31_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fir_lattice_filter_q31_core
// Self-checking testbench for the Q31 FIR lattice filter core.
// ---------------------------------------------------------------------------
// Streams Q31 samples through the core under several coefficient sets and
// compares every filtered sample with a bit-exact lattice predictor. The
// predictor keeps its own copy of the coefficients and backward delays.
// Coefficients are loaded only while the filter is empty. A short directed
// part covers the field extremes, the reset coefficients, ignored writes to
// unused register indexes and the -1 * -1 product wrap. Random phases follow,
// with random idle cycles on both streams, a burst phase against a long
// receiver stall, and a phase with no idling at all.
// ---------------------------------------------------------------------------
module tb_fir_lattice_filter_q31_core;
    import fltq31_pkg::*;

    localparam int STAGE_SLOTS = 8;
    localparam int LATENCY     = 2 * NUM_STAGES;
    localparam int MAX_GAP     = 13;
    localparam int LONG_HOLD   = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 155;

    // Register map: coefficient of stage i sits at COEF0_IDX + i
    localparam logic [CFG_IDX_W-1:0] COEF0_IDX    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] UNUSED_LO_IDX = 8'd8;
    localparam logic [CFG_IDX_W-1:0] UNUSED_HI_IDX = 8'hFF;

    localparam logic [DATA_W-1:0] Q31_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q31_MAX = 32'h7FFF_FFFF;

    // Bit-exact lattice predictor and queue of expected output samples
    class lattice_scoreboard;
        logic [DATA_W-1:0] coef  [STAGE_SLOTS];
        logic [DATA_W-1:0] delay [STAGE_SLOTS];
        logic [DATA_W-1:0] filtered_q [$];
        int errors;

        function new();
            for (int i = 0; i < STAGE_SLOTS; i++) begin
                coef[i]  = '0;
                delay[i] = '0;
            end
            errors = 0;
        endfunction

        // Writes to unused indexes are dropped by the core as well
        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            if (idx < STAGE_SLOTS)
                coef[idx[$clog2(STAGE_SLOTS)-1:0]] = val;
        endfunction

        // Low 32 bits of the full product shifted right arithmetically by 31
        function logic [DATA_W-1:0] q31_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            logic signed [PROD_W-1:0] p;
            p = PROD_W'($signed(a)) * PROD_W'($signed(b));
            return p[Q_SHIFT+DATA_W-1:Q_SHIFT];
        endfunction

        // Run one accepted sample through the lattice and queue the output
        function void note_sample(logic [DATA_W-1:0] sample);
            int n;
            logic [DATA_W-1:0] f, g_in, g_old, f_next, g_next;
            n = (NUM_STAGES > STAGE_SLOTS) ? STAGE_SLOTS : (NUM_STAGES < 1) ? 1 : NUM_STAGES;
            f = sample;
            g_in = sample;
            for (int i = 0; i < n; i++) begin
                g_old    = delay[i];
                f_next   = q31_mul(g_old, coef[i]) + f;
                g_next   = q31_mul(f, coef[i]) + g_old;
                delay[i] = g_in;
                g_in     = g_next;
                f        = f_next;
            end
            filtered_q.push_back(f);
        endfunction

        function void check_sample(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (filtered_q.size() == 0) begin
                $error("sample_out: no sample expected, actual %h", got);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                if (got !== want) begin
                    $error("sample_out: expected %h, actual %h", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;   // [31:0] sample_in
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;          // [31:0] sample_out
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data  = '0;

    lattice_scoreboard sb = new();

    // Idle control shared by the stream processes
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold  = 1'b0;

    logic [DATA_W-1:0] coef_set [STAGE_SLOTS];

    fir_lattice_filter_q31_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Q31 value biased toward the extremes, zero and small magnitudes
    function automatic logic [DATA_W-1:0] pick_q31();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = Q31_MIN;
            1: v = Q31_MAX;
            2: v = '0;
            3: v = DATA_W'($urandom_range(0, 511)) - 32'd256;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // One coefficient write transaction; cfg_valid stays high for the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_coef(idx, val);
    endtask

    // Load coef_set into all stages, with a few writes to unused indexes mixed in
    task automatic load_coefs();
        write_reg(UNUSED_LO_IDX, $urandom());
        for (int i = 0; i < STAGE_SLOTS; i++)
            write_reg(COEF0_IDX + CFG_IDX_W'(i), coef_set[i]);
        write_reg(UNUSED_HI_IDX, $urandom());
        write_reg(CFG_IDX_W'($urandom_range(STAGE_SLOTS, 255)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Offer one sample; valid is dropped only when an idle gap follows
    task automatic send_sample(input logic [DATA_W-1:0] sample);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(sample);
    endtask

    // Stop sending and wait until the chain is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Result side: random back-pressure, one long hold on request
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (long_hold) begin
                gap = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_sample(m_tdata);
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset coefficients are zero: samples pass straight through
        send_sample('0);
        send_sample(Q31_MAX);
        send_sample(Q31_MIN);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        drain();

        // All coefficients at -1.0: min * min product wraps back to min
        for (int i = 0; i < STAGE_SLOTS; i++) coef_set[i] = Q31_MIN;
        load_coefs();
        send_sample(Q31_MIN);
        send_sample(Q31_MIN);
        send_sample(Q31_MIN);
        send_sample(Q31_MAX);
        send_sample('0);
        send_sample(Q31_MIN);
        drain();

        // All coefficients at the positive extreme
        for (int i = 0; i < STAGE_SLOTS; i++) coef_set[i] = Q31_MAX;
        load_coefs();
        send_sample(Q31_MAX);
        send_sample(Q31_MIN);
        send_sample(Q31_MAX);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_sample('0);
        drain();

        // Mixed signs and magnitudes across the stages
        coef_set = '{Q31_MAX, Q31_MIN, 32'h4000_0000, 32'hC000_0000,
                     32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, Q31_MAX};
        load_coefs();
        send_sample(Q31_MIN);
        send_sample(Q31_MAX);
        send_sample($urandom());
        send_sample($urandom());
        send_sample(32'hFFFF_FFFF);
        drain();

        // Random phases, each under a fresh coefficient set
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int i = 0; i < STAGE_SLOTS; i++) coef_set[i] = pick_q31();
            load_coefs();
            tx_idle_on = (ph != 0) && (ph != 1);
            rx_idle_on = (ph != 1);
            // Burst against a long receiver hold so the chain fills and stalls
            if (ph == 0)
                long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_q31());
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/fltq31_pkg.sv
hw/rtl/fltq31_coef_regs.sv
hw/rtl/fltq31_cell.sv
hw/rtl/fir_lattice_filter_q31_core.sv
hw/rtl/fltq31_chk.sv
tb/tb_fir_lattice_filter_q31_core.sv
